// File: design/hpe_pkg.sv
// Package for the HPACK Huffman encoder: code ROM, widths and the queue entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hpe_pkg;
    localparam int SymW = 8;
    localparam int LenW = 5;
    localparam int CodeW = 30;
    localparam int QueueDepthDef = 2;

    // One classified symbol: code length, code bits, end-of-string flag.
    typedef struct packed {
        logic [LenW-1:0]  len;
        logic [CodeW-1:0] code;
        logic             last;
    } code_entry_t;

    localparam logic [4:0] CODE_LEN [256] = '{
        13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
        28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
        6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
        5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
        13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
        7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
        15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
        6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
        20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
        24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
        22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
        21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
        26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
        19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
        20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
        26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26
    };

    localparam logic [29:0] CODE_VAL [256] = '{
        30'h1FF8,30'h7FFFD8,30'hFFFFFE2,30'hFFFFFE3,30'hFFFFFE4,30'hFFFFFE5,30'hFFFFFE6,
        30'hFFFFFE7,30'hFFFFFE8,30'hFFFFEA,30'h3FFFFFFC,30'hFFFFFE9,30'hFFFFFEA,30'h3FFFFFFD,
        30'hFFFFFEB,30'hFFFFFEC,30'hFFFFFED,30'hFFFFFEE,30'hFFFFFEF,30'hFFFFFF0,30'hFFFFFF1,
        30'hFFFFFF2,30'h3FFFFFFE,30'hFFFFFF3,30'hFFFFFF4,30'hFFFFFF5,30'hFFFFFF6,30'hFFFFFF7,
        30'hFFFFFF8,30'hFFFFFF9,30'hFFFFFFA,30'hFFFFFFB,
        30'h14,30'h3F8,30'h3F9,30'hFFA,30'h1FF9,30'h15,30'hF8,30'h7FA,
        30'h3FA,30'h3FB,30'hF9,30'h7FB,30'hFA,30'h16,30'h17,30'h18,
        30'h0,30'h1,30'h2,30'h19,30'h1A,30'h1B,30'h1C,30'h1D,
        30'h1E,30'h1F,30'h5C,30'hFB,30'h7FFC,30'h20,30'hFFB,30'h3FC,
        30'h1FFA,30'h21,30'h5D,30'h5E,30'h5F,30'h60,30'h61,30'h62,
        30'h63,30'h64,30'h65,30'h66,30'h67,30'h68,30'h69,30'h6A,
        30'h6B,30'h6C,30'h6D,30'h6E,30'h6F,30'h70,30'h71,30'h72,
        30'hFC,30'h73,30'hFD,30'h1FFB,30'h7FFF0,30'h1FFC,30'h3FFC,30'h22,
        30'h7FFD,30'h3,30'h23,30'h4,30'h24,30'h5,30'h25,30'h26,
        30'h27,30'h6,30'h74,30'h75,30'h28,30'h29,30'h2A,30'h7,
        30'h2B,30'h76,30'h2C,30'h8,30'h9,30'h2D,30'h77,30'h78,
        30'h79,30'h7A,30'h7B,30'h7FFE,30'h7FC,30'h3FFD,30'h1FFD,30'hFFFFFFC,
        30'hFFFE6,30'h3FFFD2,30'hFFFE7,30'hFFFE8,30'h3FFFD3,30'h3FFFD4,30'h3FFFD5,30'h7FFFD9,
        30'h3FFFD6,30'h7FFFDA,30'h7FFFDB,30'h7FFFDC,30'h7FFFDD,30'h7FFFDE,30'hFFFFEB,30'h7FFFDF,
        30'hFFFFEC,30'hFFFFED,30'h3FFFD7,30'h7FFFE0,30'hFFFFEE,30'h7FFFE1,30'h7FFFE2,30'h7FFFE3,
        30'h7FFFE4,30'h1FFFDC,30'h3FFFD8,30'h7FFFE5,30'h3FFFD9,30'h7FFFE6,30'h7FFFE7,30'hFFFFEF,
        30'h3FFFDA,30'h1FFFDD,30'hFFFE9,30'h3FFFDB,30'h3FFFDC,30'h7FFFE8,30'h7FFFE9,30'h1FFFDE,
        30'h7FFFEA,30'h3FFFDD,30'h3FFFDE,30'hFFFFF0,30'h1FFFDF,30'h3FFFDF,30'h7FFFEB,30'h7FFFEC,
        30'h1FFFE0,30'h1FFFE1,30'h3FFFE0,30'h1FFFE2,30'h7FFFED,30'h3FFFE1,30'h7FFFEE,30'h7FFFEF,
        30'hFFFEA,30'h3FFFE2,30'h3FFFE3,30'h3FFFE4,30'h7FFFF0,30'h3FFFE5,30'h3FFFE6,30'h7FFFF1,
        30'h3FFFFE0,30'h3FFFFE1,30'hFFFEB,30'h7FFF1,30'h3FFFE7,30'h7FFFF2,30'h3FFFE8,30'h1FFFFEC,
        30'h3FFFFE2,30'h3FFFFE3,30'h3FFFFE4,30'h7FFFFDE,30'h7FFFFDF,30'h3FFFFE5,30'hFFFFF1,
        30'h1FFFFED,30'h7FFF2,30'h1FFFE3,30'h3FFFFE6,30'h7FFFFE0,30'h7FFFFE1,30'h3FFFFE7,
        30'h7FFFFE2,30'hFFFFF2,30'h1FFFE4,30'h1FFFE5,30'h3FFFFE8,30'h3FFFFE9,30'hFFFFFFD,
        30'h7FFFFE3,30'h7FFFFE4,30'h7FFFFE5,30'hFFFEC,30'hFFFFF3,30'hFFFED,30'h1FFFE6,
        30'h3FFFE9,30'h1FFFE7,30'h1FFFE8,30'h7FFFF3,30'h3FFFEA,30'h3FFFEB,30'h1FFFFEE,
        30'h1FFFFEF,30'hFFFFF4,30'hFFFFF5,30'h3FFFFEA,30'h7FFFF4,30'h3FFFFEB,30'h7FFFFE6,
        30'h3FFFFEC,30'h3FFFFED,30'h7FFFFE7,30'h7FFFFE8,30'h7FFFFE9,30'h7FFFFEA,30'h7FFFFEB,
        30'hFFFFFFE,30'h7FFFFEC,30'h7FFFFED,30'h7FFFFEE,30'h7FFFFEF,30'h7FFFFF0,30'h3FFFFEE
    };
endpackage
`default_nettype wire

// File: design/hpe_front.sv
// Front end: accepts symbols, looks up the Huffman code and registers it.
// Depends on hpe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpe_front (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire [7:0]                s_symbol,
    input  wire                      s_end_of_string,
    input  wire                      s_valid,
    output logic                     s_ready,
    output hpe_pkg::code_entry_t     f_entry,
    output logic                     f_valid,
    input  wire                      f_ready
);
    import hpe_pkg::*;

    logic        valid_reg;
    code_entry_t entry_reg;

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_entry = entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            entry_reg.len  <= CODE_LEN[s_symbol];
            entry_reg.code <= CODE_VAL[s_symbol];
            entry_reg.last <= s_end_of_string;
        end
    end
endmodule
`default_nettype wire

// File: design/hpe_queue.sv
// Short FIFO of classified codes between front and back ends.
// Depends on hpe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpe_queue #(
    parameter int Depth = hpe_pkg::QueueDepthDef
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  hpe_pkg::code_entry_t  in_entry,
    input  wire                   in_valid,
    output logic                  in_ready,
    output hpe_pkg::code_entry_t  out_entry,
    output logic                  out_valid,
    input  wire                   out_ready
);
    import hpe_pkg::*;
    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

    code_entry_t          mem_reg [Depth];
    logic [PtrW-1:0]      wr_reg, rd_reg;
    logic [PtrW:0]        cnt_reg;
    logic                 push, pop;

    assign in_ready  = cnt_reg != (PtrW+1)'(Depth);
    assign out_valid = cnt_reg != '0;
    assign out_entry = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PtrW'(Depth-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PtrW'(Depth-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
        if (push) begin
            mem_reg[wr_reg] <= in_entry;
        end
    end
endmodule
`default_nettype wire

// File: design/hpe_back.sv
// Back end: packs code bits behind pending bits, one byte out a cycle unless stalled.
// Depends on hpe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpe_back (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  hpe_pkg::code_entry_t  q_entry,
    input  wire                   q_valid,
    output logic                  q_ready,
    output logic [7:0]            m_code_byte,
    output logic                  m_final_byte,
    output logic                  m_valid,
    input  wire                   m_ready
);
    import hpe_pkg::*;

    // acc holds up to 7 pending + 30 code bits, right-aligned
    logic [36:0] acc_reg, acc_next;
    logic [5:0]  tot_reg, tot_next;
    logic        busy_reg, busy_next;
    logic        last_reg, last_next;
    logic [7:0]  byte_reg, byte_next;
    logic        fin_reg, fin_next;
    logic        ov_reg, ov_next;
    logic        out_free, load;
    logic [36:0] shifted;
    logic [6:0]  pend;
    logic [2:0]  pad;
    logic [7:0]  head;

    assign out_free  = !ov_reg || m_ready;
    assign q_ready   = !busy_reg;
    assign load      = q_valid && !busy_reg;
    assign m_valid   = ov_reg;
    assign m_code_byte  = byte_reg;
    assign m_final_byte = fin_reg;

    always_comb begin
        acc_next  = acc_reg;
        tot_next  = tot_reg;
        busy_next = busy_reg;
        last_next = last_reg;
        byte_next = byte_reg;
        fin_next  = fin_reg;
        ov_next   = ov_reg && !m_ready;
        shifted   = '0;
        pend      = '0;
        pad       = '0;
        head      = '0;
        if (load) begin
            // keep only the valid pending bits, placed above the new code
            pend      = acc_reg[6:0] & ~(7'h7F << tot_reg[2:0]);
            acc_next  = (37'(pend) << q_entry.len) | 37'(q_entry.code);
            tot_next  = tot_reg + 6'(q_entry.len);
            last_next = q_entry.last;
            // a short code that does not end the string just joins the pending bits
            busy_next = q_entry.last || (tot_reg + 6'(q_entry.len) >= 6'd8);
        end else if (busy_reg && out_free) begin
            if (tot_reg >= 6'd8) begin
                shifted   = acc_reg >> (tot_reg - 6'd8);
                byte_next = shifted[7:0];
                tot_next  = tot_reg - 6'd8;
                ov_next   = 1'b1;
                fin_next  = last_reg && (tot_reg == 6'd8);
                if (tot_reg - 6'd8 < 6'd8 && !(last_reg && tot_reg != 6'd8)) begin
                    busy_next = 1'b0;
                    if (last_reg) begin
                        tot_next = '0;
                        acc_next = '0;
                    end
                end
            end else begin
                // pad the partial byte with ones
                pad       = 3'(4'd8 - 4'(tot_reg));
                head      = acc_reg[7:0] << pad;
                byte_next = head | ~(8'hFF << pad);
                fin_next  = 1'b1;
                ov_next   = 1'b1;
                busy_next = 1'b0;
                tot_next  = '0;
                acc_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tot_reg  <= '0;
            acc_reg  <= '0;
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            last_reg <= 1'b0;
        end else begin
            tot_reg  <= tot_next;
            acc_reg  <= acc_next;
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
            last_reg <= last_next;
        end
        byte_reg <= byte_next;
        fin_reg  <= fin_next;
    end
endmodule
`default_nettype wire

// File: design/hpack_huffman_encoder.sv
// Channel  | ports                                   | transaction
// s_       | s_symbol, s_end_of_string, s_valid/ready | one symbol
// m_       | m_code_byte, m_final_byte, m_valid/ready | one coded byte
// A symbol loads into the back end, then leaves as 0 to 5 coded bytes through the
// byte-wide output; the back end takes no new symbol while it has bytes to emit.
// Lookup and byte are registered; the queue lets symbols enter while bytes drain.
// Synchronous active-low reset clears the pending bits and all valid flags.
// Top level; depends on hpe_pkg, hpe_front, hpe_queue, hpe_back.
`timescale 1ns / 1ps
`default_nettype none
module hpack_huffman_encoder #(
    parameter int QueueDepth = hpe_pkg::QueueDepthDef
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire [7:0]  s_symbol,
    input  wire        s_end_of_string,
    input  wire        s_valid,
    output logic       s_ready,
    output logic [7:0] m_code_byte,
    output logic       m_final_byte,
    output logic       m_valid,
    input  wire        m_ready
);
    import hpe_pkg::*;

    code_entry_t f_entry, q_entry;
    logic f_valid, f_ready, q_valid, q_ready;

    hpe_front u_front (
        .aclk, .aresetn, .s_symbol, .s_end_of_string, .s_valid, .s_ready,
        .f_entry, .f_valid, .f_ready
    );

    hpe_queue #(.Depth(QueueDepth)) u_queue (
        .aclk, .aresetn,
        .in_entry(f_entry), .in_valid(f_valid), .in_ready(f_ready),
        .out_entry(q_entry), .out_valid(q_valid), .out_ready(q_ready)
    );

    hpe_back u_back (
        .aclk, .aresetn, .q_entry, .q_valid, .q_ready,
        .m_code_byte, .m_final_byte, .m_valid, .m_ready
    );
endmodule
`default_nettype wire

// File: design/hpe_checker.sv
// Port-level checker for the HPACK Huffman encoder, bound to the top level.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module hpe_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_ready,
    input wire [7:0] m_code_byte,
    input wire       m_final_byte,
    input wire       m_valid,
    input wire       m_ready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_byte) && $stable(m_final_byte))
        else $error("result changed under stall");
    a_rst_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
    a_no_out_from_nothing: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result without input");
    a_ready_rst: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");
endmodule

bind hpack_huffman_encoder hpe_checker u_hpe_checker (
    .aclk, .aresetn, .s_ready, .m_code_byte, .m_final_byte, .m_valid, .m_ready
);
`default_nettype wire
